// File: design/vzd_pkg.sv
// Package for the LEB128 varint / zigzag decoder.
// Kind and status codes plus the finish (range check, zigzag) function.
// No dependencies.
package vzd_pkg;

  localparam int unsigned ValW   = 64;
  localparam int unsigned CntW   = 4;
  localparam int unsigned KindW  = 3;
  localparam int unsigned StatW  = 2;
  localparam logic [CntW-1:0] MaxBytes = 4'd10;

  // requested kinds; codes 6 and 7 decode as u64
  localparam logic [KindW-1:0] KIND_U16 = 3'd0;
  localparam logic [KindW-1:0] KIND_U32 = 3'd1;
  localparam logic [KindW-1:0] KIND_U64 = 3'd2;
  localparam logic [KindW-1:0] KIND_I16 = 3'd3;
  localparam logic [KindW-1:0] KIND_I32 = 3'd4;
  localparam logic [KindW-1:0] KIND_I64 = 3'd5;

  localparam logic [StatW-1:0] STATUS_OK      = 2'd0;
  localparam logic [StatW-1:0] STATUS_SHORT   = 2'd1;
  localparam logic [StatW-1:0] STATUS_TOO_BIG = 2'd2;

  typedef struct packed {
    logic [ValW-1:0]  value;
    logic [StatW-1:0] status;
  } finish_t;

  // range check for the kind, zigzag for the signed kinds; value 0 on error
  function automatic finish_t finish_value(logic [ValW-1:0] raw, logic [KindW-1:0] kind);
    finish_t    res;
    logic       fits32;
    logic [31:0] z32;
    logic [16:0] top;
    logic [ValW-1:0] z64;
    fits32 = (raw[63:32] == 32'd0);
    z32    = {1'b0, raw[31:1]} ^ {32{raw[0]}};
    top    = z32[31:15];
    z64    = {1'b0, raw[63:1]} ^ {64{raw[0]}};
    res.value  = '0;
    res.status = STATUS_OK;
    case (kind)
      KIND_U16: begin
        if (raw[63:16] != 48'd0) res.status = STATUS_TOO_BIG;
        else res.value = raw;
      end
      KIND_U32: begin
        if (!fits32) res.status = STATUS_TOO_BIG;
        else res.value = raw;
      end
      KIND_I16, KIND_I32: begin
        if (!fits32) begin
          res.status = STATUS_TOO_BIG;
        end else if (kind == KIND_I16 && top != 17'd0 && top != 17'h1FFFF) begin
          res.status = STATUS_TOO_BIG;
        end else begin
          res.value = {{32{z32[31]}}, z32};
        end
      end
      KIND_I64: res.value = z64;
      default:  res.value = raw;
    endcase
    return res;
  endfunction

endpackage

// File: design/varint_zigzag_decoder_top.sv
// Top level of the LEB128 varint decoder with zigzag decoding.
// Input register, accumulate/finish logic and result register.
// Depends on vzd_pkg.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one varint byte per
//    item with the requested kind (cmd_i, sampled with the first byte) and
//    buffer_end_i, which ends the current value with status "data short".
//  - Output channel (out_valid_o / out_ready_i) carries one result item per
//    finished value: value, status and number of bytes consumed.
//  - Throughput: one item per cycle, sustained while the receiver does not stall,
//    set by the single pass of shift/OR/compare logic between the input register and result register.
//  - Result path: the ending byte is captured in the input register, and its
//    result then loads into the result register, which raises out_valid_o.
//  - Receiver stall: the result register holds; the item in the input
//    register still advances if it causes no result, otherwise it waits and
//    in_ready_o drops once the input register is full.
//  - Reset (rst_ni low, async): both registers empty, accumulator, byte
//    count and latched kind cleared.
module varint_zigzag_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic [2:0]  cmd_i,
  input  logic        buffer_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic [1:0]  status_o,
  output logic [3:0]  byte_count_o
);

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic [2:0]  s1_cmd_q;
  logic        s1_end_q;

  // decoder state
  logic [63:0] acc_q, acc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [2:0]  kind_q, kind_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [63:0] value_q;
  logic [1:0]  status_q;
  logic [3:0]  count_q;

  logic        can_push, produces, advance, accept;
  logic [2:0]  kind_cur;
  logic [5:0]  shift_full;
  logic [63:0] acc_new;
  logic [3:0]  cnt_new;
  logic        done;
  vzd_pkg::finish_t fin;
  logic [63:0] res_value;
  logic [1:0]  res_status;
  logic [3:0]  res_count;

  // accumulate the byte at 7 * bytes taken; count stays below ten here
  always_comb begin
    kind_cur   = (cnt_q == 4'd0) ? s1_cmd_q : kind_q;
    shift_full = {2'b00, cnt_q} * 6'd7;
    acc_new    = acc_q | ({57'd0, s1_byte_q[6:0]} << shift_full);
    cnt_new    = cnt_q + 4'd1;
    done       = !s1_byte_q[7] || (cnt_new == vzd_pkg::MaxBytes);
    fin        = vzd_pkg::finish_value(acc_new, kind_cur);
  end

  // result selection: end-of-data beats byte completion
  always_comb begin
    if (s1_end_q) begin
      res_value  = '0;
      res_status = vzd_pkg::STATUS_SHORT;
      res_count  = cnt_q;
    end else begin
      res_value  = fin.value;
      res_status = fin.status;
      res_count  = cnt_new;
    end
  end

  // handshake: item in the input register moves on unless its result is
  // blocked by a full, stalled result register
  always_comb begin
    can_push    = !out_valid_q || out_ready_i;
    produces    = s1_end_q || done;
    advance     = s1_valid_q && (!produces || can_push);
    in_ready_o  = !s1_valid_q || advance;
    accept      = in_valid_i && in_ready_o;
    s1_valid_d  = accept || (s1_valid_q && !advance);
    out_valid_d = (advance && produces) || (out_valid_q && !out_ready_i);
  end

  // next decoder state; clears after every result
  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    kind_d = kind_q;
    if (advance) begin
      if (produces) begin
        acc_d  = '0;
        cnt_d  = '0;
        kind_d = '0;
      end else begin
        acc_d  = acc_new;
        cnt_d  = cnt_new;
        kind_d = kind_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      kind_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      kind_q      <= kind_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= data_byte_i;
      s1_cmd_q  <= cmd_i;
      s1_end_q  <= buffer_end_i;
    end
    if (advance && produces) begin
      value_q  <= res_value;
      status_q <= res_status;
      count_q  <= res_count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign status_o     = status_q;
  assign byte_count_o = count_q;

endmodule

// File: sim/tb_varint_zigzag_decoder_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for varint_zigzag_decoder_top: directed and random
// varint byte streams, checked against an in-bench shadow decoder.
// Depends on vzd_pkg and the decoder RTL.
module tb_varint_zigzag_decoder_top;

  localparam int NumItems   = 750;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 10;
  localparam logic [vzd_pkg::KindW-1:0] KIND_UNUSED = 3'd7;

  typedef enum logic [1:0] {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  typedef struct packed {
    logic [7:0]                data;
    logic [vzd_pkg::KindW-1:0] kind;
    logic                      fin;
    idle_mode_e                mode;
  } byte_item_t;

  typedef struct packed {
    logic [vzd_pkg::ValW-1:0]  value;
    logic [vzd_pkg::StatW-1:0] status;
    logic [vzd_pkg::CntW-1:0]  count;
  } decoded_t;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid     = 1'b0;
  logic [7:0]                data_byte    = '0;
  logic [vzd_pkg::KindW-1:0] cmd          = '0;
  logic                      buffer_end   = 1'b0;
  logic                      out_ready    = 1'b0;
  idle_mode_e                cur_mode     = IdleNone;
  logic                      in_ready_o;
  logic                      out_valid_o;
  logic [63:0]               value_o;
  logic [1:0]                status_o;
  logic [3:0]                byte_count_o;

  byte_item_t byte_q[$];
  decoded_t   decoded_q[$];

  // shadow decoder state
  logic [vzd_pkg::ValW-1:0]  shadow_acc  = '0;
  logic [vzd_pkg::CntW-1:0]  shadow_cnt  = '0;
  logic [vzd_pkg::KindW-1:0] shadow_kind = vzd_pkg::KIND_U16;

  int n_errors = 0;
  int n_in     = 0;
  int n_ok     = 0;
  int n_short  = 0;
  int n_big    = 0;
  int cycles   = 0;

  varint_zigzag_decoder_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte),
    .cmd_i        (cmd),
    .buffer_end_i (buffer_end),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .value_o      (value_o),
    .status_o     (status_o),
    .byte_count_o (byte_count_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic push_byte(input logic [7:0] b, input logic [vzd_pkg::KindW-1:0] k,
                           input logic fin, input idle_mode_e m);
    byte_q.push_back('{data: b, kind: k, fin: fin, mode: m});
  endtask

  // Absorb one accepted byte; queue the decoded result when a value ends.
  task automatic leb_absorb(input logic [7:0] b, input logic [vzd_pkg::KindW-1:0] k,
                            input logic fin);
    decoded_t          r;
    logic              done;
    logic [31:0]       half;
    logic signed [31:0] zs;
    r    = '0;
    done = 1'b0;
    if (fin) begin
      r.status = vzd_pkg::STATUS_SHORT;
      r.count  = shadow_cnt;
      done     = 1'b1;
    end else begin
      if (shadow_cnt == '0) shadow_kind = k;
      shadow_acc = shadow_acc | (64'(b[6:0]) << (7 * shadow_cnt));
      shadow_cnt = shadow_cnt + 1'b1;
      if (!b[7] || shadow_cnt == vzd_pkg::MaxBytes) begin
        done     = 1'b1;
        r.count  = shadow_cnt;
        r.status = vzd_pkg::STATUS_OK;
        case (shadow_kind)
          vzd_pkg::KIND_U16: begin
            if (shadow_acc > 64'hFFFF) r.status = vzd_pkg::STATUS_TOO_BIG;
            else r.value = shadow_acc;
          end
          vzd_pkg::KIND_U32: begin
            if (shadow_acc > 64'hFFFF_FFFF) r.status = vzd_pkg::STATUS_TOO_BIG;
            else r.value = shadow_acc;
          end
          vzd_pkg::KIND_I16, vzd_pkg::KIND_I32: begin
            half = shadow_acc[31:0];
            zs   = (half >> 1) ^ {32{half[0]}};
            if (shadow_acc > 64'hFFFF_FFFF) r.status = vzd_pkg::STATUS_TOO_BIG;
            else if (shadow_kind == vzd_pkg::KIND_I16 && (zs < -32768 || zs > 32767))
              r.status = vzd_pkg::STATUS_TOO_BIG;
            else r.value = {{32{zs[31]}}, zs};
          end
          vzd_pkg::KIND_I64: r.value = (shadow_acc >> 1) ^ {64{shadow_acc[0]}};
          default:           r.value = shadow_acc;
        endcase
      end
    end
    if (done) begin
      decoded_q.push_back(r);
      shadow_acc  = '0;
      shadow_cnt  = '0;
      shadow_kind = vzd_pkg::KIND_U16;
    end
  endtask

  // driver: next item goes out once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready_o) begin
      if (byte_q.size() != 0 &&
          $urandom_range(0, 99) >= ((byte_q[0].mode == IdleSender) ? 78 :
                                    (byte_q[0].mode == IdleBoth)   ? 28 : 0)) begin
        in_valid   <= 1'b1;
        data_byte  <= byte_q[0].data;
        cmd        <= byte_q[0].kind;
        buffer_end <= byte_q[0].fin;
        cur_mode   <= byte_q[0].mode;
        void'(byte_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= ((cur_mode == IdleReceiver) ? 78 :
                                              (cur_mode == IdleBoth)     ? 28 : 0);
    end
  end

  // monitor: check results, then predict from accepted bytes
  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        case (status_o)
          vzd_pkg::STATUS_OK:      n_ok++;
          vzd_pkg::STATUS_SHORT:   n_short++;
          vzd_pkg::STATUS_TOO_BIG: n_big++;
          default: ;
        endcase
        if (decoded_q.size() == 0) begin
          $error("result with nothing expected: value %h status %0d byte_count %0d",
                 value_o, status_o, byte_count_o);
          n_errors++;
        end else begin
          want = decoded_q.pop_front();
          if (value_o !== want.value) begin
            $error("value: expected %h, got %h", want.value, value_o);
            n_errors++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            n_errors++;
          end
          if (byte_count_o !== want.count) begin
            $error("byte_count: expected %0d, got %0d", want.count, byte_count_o);
            n_errors++;
          end
        end
      end
      if (in_valid && in_ready_o) begin
        n_in++;
        leb_absorb(data_byte, cmd, buffer_end);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, decoded_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int                        n_directed;
    int                        len;
    int                        cut;
    int                        roll;
    idle_mode_e                mode;
    logic [vzd_pkg::KindW-1:0] kind;
    logic [7:0]                b;

    // directed: end with no bytes, i16 range edges, tenth byte, unused code
    push_byte(8'hFF, vzd_pkg::KIND_U32, 1'b1, IdleNone);
    push_byte(8'h7F, vzd_pkg::KIND_U16, 1'b0, IdleNone);
    push_byte(8'hFF, vzd_pkg::KIND_I16, 1'b0, IdleNone);   // raw 0xFFFF -> -32768
    push_byte(8'hFF, vzd_pkg::KIND_U64, 1'b0, IdleNone);
    push_byte(8'h03, vzd_pkg::KIND_U64, 1'b0, IdleNone);
    push_byte(8'h80, vzd_pkg::KIND_I16, 1'b0, IdleNone);   // raw 0x10000 -> out of i16
    push_byte(8'h80, vzd_pkg::KIND_I16, 1'b0, IdleNone);
    push_byte(8'h04, vzd_pkg::KIND_I16, 1'b0, IdleNone);
    for (int i = 0; i < 10; i++)                          // tenth byte ends with top bit set
      push_byte(8'hFF, (i == 0) ? vzd_pkg::KIND_U64 : vzd_pkg::KIND_I16, 1'b0, IdleNone);
    push_byte(8'h01, KIND_UNUSED, 1'b0, IdleNone);
    push_byte(8'h01, vzd_pkg::KIND_I64, 1'b0, IdleNone);
    push_byte(8'h02, vzd_pkg::KIND_I32, 1'b0, IdleNone);
    push_byte(8'h80, vzd_pkg::KIND_U32, 1'b0, IdleNone);   // cut short after one byte
    push_byte(8'h00, vzd_pkg::KIND_U16, 1'b1, IdleNone);
    n_directed = byte_q.size();

    // random: mostly well-formed varints, some cut short, some stray ends
    while (byte_q.size() < NumItems) begin
      mode = idle_mode_e'(((byte_q.size() - n_directed) * 4) / (NumItems - n_directed));
      kind = 3'($urandom_range(0, 7));
      case (kind)
        vzd_pkg::KIND_U16, vzd_pkg::KIND_I16: len = $urandom_range(1, 4);
        vzd_pkg::KIND_U32, vzd_pkg::KIND_I32: len = $urandom_range(1, 6);
        default:                              len = $urandom_range(1, 10);
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        push_byte(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 1'b1, mode);
      end else begin
        cut = (roll < 20) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < cut; i++) begin
          b = 8'($urandom_range(0, 255));
          if (i != len - 1) begin
            b[7] = 1'b1;
          end else if (len < 10) begin
            b[7]   = 1'b0;
            b[6:0] = b[6:0] >> $urandom_range(0, 6);   // small tops hit range edges
          end
          // later bytes carry a random kind that must be ignored
          push_byte(b, (i == 0) ? kind : 3'($urandom_range(0, 7)), 1'b0, mode);
        end
        if (cut < len)
          push_byte(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 1'b1, mode);
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (byte_q.size() != 0 || in_valid) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Fed %0d bytes over four idle/stall phases; %0d results compared",
             n_in, n_ok + n_short + n_big);
    $display("Result status mix: %0d ok, %0d data short, %0d too big; %0d field errors",
             n_ok, n_short, n_big, n_errors);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/vzd_pkg.sv
design/varint_zigzag_decoder_top.sv
sim/tb_varint_zigzag_decoder_top.sv
